### hdl/rgsc_pkg.sv
// Package for the rain gate stepper controller: payload structs, register
// indexes, reset values and the half-step coil table.
// No dependencies; every other file in hdl uses it.
package rgsc_pkg;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic [1:0] REG_PRESSURE_LIMIT = 2'd0;
	localparam logic [1:0] REG_FULL_DISTANCE  = 2'd1;
	localparam logic [1:0] REG_MOVE_STEPS     = 2'd2;

	localparam logic [11:0] PRESSURE_LIMIT_RST = 12'd30;
	localparam logic [8:0]  FULL_DISTANCE_RST  = 9'd25;
	localparam logic [15:0] MOVE_STEPS_RST     = 16'd500;

	localparam int unsigned CFG_DATA_W = 16;

	typedef struct packed {
		logic        command;
		logic        rain_wet;
		logic [11:0] pressure_sample;
		logic [8:0]  distance_left;
		logic [8:0]  distance_right;
	} in_t;

	typedef struct packed {
		logic [3:0] coil_pattern;
		logic       motor_on;
		logic       bin_full;
		logic       last_action_open;
	} out_t;

	typedef struct packed {
		logic [11:0] pressure_limit;
		logic [8:0]  full_distance;
		logic [15:0] move_steps;
	} cfg_t;

	function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
		logic [3:0] pat;
		case (phase)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

### hdl/rain_gate_stepper_controller_core.sv
// Top level of the rain gate stepper controller: input register, result
// register and configuration registers around rgsc_step. Uses rgsc_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  in       | in_valid / in_stall  | in_data  (rgsc_pkg::in_t)
//  out      | out_valid / out_stall| out_data (rgsc_pkg::out_t)
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// An accepted beat is held in the input register and passes through the
// state update into the result register, from which its result is offered.
// One beat is accepted per cycle when the output is not stalled; the sequencer
// state is updated combinationally and registered as each beat advances.
// Reset empties both registers and restores the default configuration.
// A stall on the output holds the result and, once the input register is
// also full, raises in_stall in the same cycle.
module rain_gate_stepper_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rgsc_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rgsc_pkg::out_t                    out_data,
	input  logic                              cfg_write,
	input  logic [1:0]                        cfg_index,
	input  logic [rgsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rgsc_pkg::in_t  item_s1;
	logic           valid_s1;
	rgsc_pkg::out_t result_d;
	rgsc_pkg::out_t out_data_q;
	logic           out_valid_q;
	rgsc_pkg::cfg_t cfg_q;
	logic           advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressure_limit <= rgsc_pkg::PRESSURE_LIMIT_RST;
			cfg_q.full_distance  <= rgsc_pkg::FULL_DISTANCE_RST;
			cfg_q.move_steps     <= rgsc_pkg::MOVE_STEPS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				rgsc_pkg::REG_PRESSURE_LIMIT: cfg_q.pressure_limit <= cfg_data[11:0];
				rgsc_pkg::REG_FULL_DISTANCE:  cfg_q.full_distance  <= cfg_data[8:0];
				rgsc_pkg::REG_MOVE_STEPS:     cfg_q.move_steps     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rgsc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (result_d)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hdl/rgsc_step.sv
// Sequencer state and its single-pass update for one tick or poll beat.
// Depends on rgsc_pkg for the payload, configuration and coil table.
module rgsc_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  rgsc_pkg::in_t     item,
	input  rgsc_pkg::cfg_t    cfg,
	output rgsc_pkg::out_t    result
);

	logic [2:0]  phase_q,    phase_d;
	logic [15:0] steps_q,    steps_d;
	logic        back_q,     back_d;
	logic        last_open_q, last_open_d;
	logic        enabled_q,  enabled_d;
	logic [3:0]  coil_q,     coil_d;
	logic        full_q,     full_d;

	always_comb begin
		phase_d     = phase_q;
		steps_d     = steps_q;
		back_d      = back_q;
		last_open_d = last_open_q;
		enabled_d   = enabled_q;
		coil_d      = coil_q;
		full_d      = full_q;
		if (item.command == rgsc_pkg::CMD_POLL) begin
			full_d = (item.distance_left < cfg.full_distance) &&
				(item.distance_right < cfg.full_distance);
			if (!enabled_q) begin
				if (item.rain_wet && (item.pressure_sample < cfg.pressure_limit) &&
					!last_open_q) begin
					back_d      = 1'b0;
					steps_d     = '0;
					last_open_d = 1'b1;
				end else if (!item.rain_wet && last_open_q) begin
					back_d      = 1'b1;
					steps_d     = '0;
					last_open_d = 1'b0;
				end
			end
			if (steps_d < cfg.move_steps) begin
				enabled_d = 1'b1;
			end else begin
				enabled_d = 1'b0;
				coil_d    = '0;
			end
		end else if (enabled_q) begin
			coil_d = rgsc_pkg::coil_lookup(phase_q);
			if (steps_q < cfg.move_steps) begin
				phase_d = back_q ? phase_q - 3'd1 : phase_q + 3'd1;
				steps_d = steps_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			steps_q     <= rgsc_pkg::MOVE_STEPS_RST;
			back_q      <= 1'b0;
			last_open_q <= 1'b0;
			enabled_q   <= 1'b0;
			coil_q      <= '0;
			full_q      <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			steps_q     <= steps_d;
			back_q      <= back_d;
			last_open_q <= last_open_d;
			enabled_q   <= enabled_d;
			coil_q      <= coil_d;
			full_q      <= full_d;
		end
	end

	assign result.coil_pattern     = coil_d;
	assign result.motor_on         = enabled_d;
	assign result.bin_full         = full_d;
	assign result.last_action_open = last_open_d;

endmodule

### bench/rain_gate_stepper_controller_core_tb.sv
// Testbench for rain_gate_stepper_controller_core: directed and random poll and tick beats,
// each checked field by field against an in-bench model of the gate sequencer.
// Depends on rgsc_pkg and the core in hdl.
module rain_gate_stepper_controller_core_tb;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [31:0] HALF_STEP = 32'h98C46231;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	rgsc_pkg::in_t                   in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	rgsc_pkg::out_t                  out_data;
	logic                            cfg_write = 1'b0;
	logic [1:0]                      cfg_index = rgsc_pkg::REG_PRESSURE_LIMIT;
	logic [rgsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [11:0] lim_pressure = rgsc_pkg::PRESSURE_LIMIT_RST;
	logic [8:0]  lim_distance = rgsc_pkg::FULL_DISTANCE_RST;
	logic [15:0] steps_per_move = rgsc_pkg::MOVE_STEPS_RST;
	logic [2:0]  phase = '0;
	logic [15:0] steps_taken = rgsc_pkg::MOVE_STEPS_RST;
	logic        reverse = 1'b0;
	logic        opened_last = 1'b0;
	logic        motor_run = 1'b0;
	logic [3:0]  coils = '0;
	logic        bin_seen = 1'b0;

	rgsc_pkg::in_t  beats_waiting[$];
	rgsc_pkg::out_t due_gate_states[$];
	rgsc_pkg::out_t due;
	int unsigned    beats_queued = 0;
	int unsigned    beats_taken = 0;
	int unsigned    mismatches = 0;
	int unsigned    quiet_cycles = 0;
	int unsigned    send_gap = 0;
	int unsigned    stall_left = 0;
	logic           in_taken = 1'b0;
	logic           idle_on = 1'b1;

	rain_gate_stepper_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rgsc_pkg::out_t advance_gate(rgsc_pkg::in_t beat);
		rgsc_pkg::out_t res;
		if (beat.command == rgsc_pkg::CMD_POLL) begin
			bin_seen = beat.distance_left < lim_distance && beat.distance_right < lim_distance;
			if (!motor_run) begin
				if (beat.rain_wet && beat.pressure_sample < lim_pressure && !opened_last) begin
					reverse = 1'b0;
					steps_taken = '0;
					opened_last = 1'b1;
				end else if (!beat.rain_wet && opened_last) begin
					reverse = 1'b1;
					steps_taken = '0;
					opened_last = 1'b0;
				end
			end
			if (steps_taken < steps_per_move) begin
				motor_run = 1'b1;
			end else begin
				motor_run = 1'b0;
				coils = '0;
			end
		end else if (motor_run) begin
			coils = HALF_STEP[4*phase +: 4];
			if (steps_taken < steps_per_move) begin
				phase = reverse ? phase - 3'd1 : phase + 3'd1;
				steps_taken = steps_taken + 16'd1;
			end
		end
		res.coil_pattern = coils;
		res.motor_on = motor_run;
		res.bin_full = bin_seen;
		res.last_action_open = opened_last;
		return res;
	endfunction

	function automatic rgsc_pkg::in_t poll_beat(logic wet, logic [11:0] pressure,
			logic [8:0] left, logic [8:0] right);
		rgsc_pkg::in_t beat;
		beat.command = rgsc_pkg::CMD_POLL;
		beat.rain_wet = wet;
		beat.pressure_sample = pressure;
		beat.distance_left = left;
		beat.distance_right = right;
		return beat;
	endfunction

	function automatic rgsc_pkg::in_t tick_beat();
		rgsc_pkg::in_t beat;
		beat = rgsc_pkg::in_t'($urandom);
		beat.command = rgsc_pkg::CMD_TICK;
		return beat;
	endfunction

	function automatic rgsc_pkg::in_t random_poll(logic wet);
		rgsc_pkg::in_t beat;
		beat = rgsc_pkg::in_t'($urandom);
		beat.command = rgsc_pkg::CMD_POLL;
		beat.rain_wet = wet;
		if ($urandom_range(0, 2) != 0)
			beat.pressure_sample = 12'($urandom_range(0, lim_pressure));
		if ($urandom_range(0, 2) != 0)
			beat.distance_left = lim_distance - 9'($urandom_range(0, 2));
		if ($urandom_range(0, 2) != 0)
			beat.distance_right = lim_distance - 9'($urandom_range(0, 2));
		return beat;
	endfunction

	task automatic queue_beat(rgsc_pkg::in_t beat);
		beats_waiting.push_back(beat);
		beats_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (beats_taken != beats_queued || due_gate_states.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [rgsc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			rgsc_pkg::REG_PRESSURE_LIMIT: lim_pressure = val[11:0];
			rgsc_pkg::REG_FULL_DISTANCE:  lim_distance = val[8:0];
			rgsc_pkg::REG_MOVE_STEPS:     steps_per_move = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned pressure, int unsigned distance, int unsigned steps);
		write_reg(rgsc_pkg::REG_PRESSURE_LIMIT, rgsc_pkg::CFG_DATA_W'(pressure));
		write_reg(rgsc_pkg::REG_FULL_DISTANCE, rgsc_pkg::CFG_DATA_W'(distance));
		write_reg(rgsc_pkg::REG_MOVE_STEPS, rgsc_pkg::CFG_DATA_W'(steps));
	endtask

	// A run is a poll that may start a move, a burst of ticks and a poll that may stop it.
	task automatic queue_runs(int unsigned count);
		int unsigned goal;
		int unsigned ticks;
		logic        wet;
		goal = beats_queued + count;
		wet = 1'($urandom_range(0, 1));
		while (beats_queued < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_beat(rgsc_pkg::in_t'($urandom));
			end else begin
				if ($urandom_range(0, 4) != 0)
					wet = !wet;
				queue_beat(random_poll(wet));
				ticks = $urandom_range(0, (steps_per_move > 37) ? 40 : steps_per_move + 3);
				repeat (ticks) queue_beat(tick_beat());
				queue_beat(random_poll(wet));
			end
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (beats_waiting.size() == 0) begin
			in_valid <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			send_gap = $urandom_range(0, 8);
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			in_data <= beats_waiting.pop_front();
		end
	end

	always @(negedge clk) begin
		if (!idle_on) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			due_gate_states.push_back(advance_gate(in_data));
			beats_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (due_gate_states.size() == 0) begin
				$error("result beat with nothing expected: %p", out_data);
				mismatches++;
			end else begin
				due = due_gate_states.pop_front();
				if (out_data.coil_pattern !== due.coil_pattern) begin
					$error("coil_pattern expected %h got %h", due.coil_pattern,
						out_data.coil_pattern);
					mismatches++;
				end
				if (out_data.motor_on !== due.motor_on) begin
					$error("motor_on expected %b got %b", due.motor_on, out_data.motor_on);
					mismatches++;
				end
				if (out_data.bin_full !== due.bin_full) begin
					$error("bin_full expected %b got %b", due.bin_full, out_data.bin_full);
					mismatches++;
				end
				if (out_data.last_action_open !== due.last_action_open) begin
					$error("last_action_open expected %b got %b", due.last_action_open,
						out_data.last_action_open);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("rain_gate_stepper_controller_core_tb failed");
			$finish;
		end
	end

	initial begin
		int unsigned seg;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Default settings: refused opening, refused closing, then a long opening move.
		queue_beat(poll_beat(1'b1, 12'd4095, 9'd511, 9'd511));
		queue_beat(poll_beat(1'b0, 12'd0, 9'd0, 9'd0));
		queue_beat(poll_beat(1'b1, 12'd29, 9'd24, 9'd24));
		queue_beat(tick_beat());
		queue_beat(tick_beat());
		queue_beat(poll_beat(1'b1, 12'd0, 9'd25, 9'd0));
		wait_drained();

		// The move length drops to the steps already taken, so the move counts as done.
		set_config(12'hFFF, 9'h1FF, 2);
		queue_beat(tick_beat());
		queue_beat(poll_beat(1'b1, 12'd0, 9'd510, 9'd510));
		queue_beat(poll_beat(1'b1, 12'd0, 9'd510, 9'd510));
		queue_beat(poll_beat(1'b0, 12'd4095, 9'd511, 9'd511));
		repeat (3) queue_beat(tick_beat());
		queue_beat(poll_beat(1'b0, 12'd0, 9'd0, 9'd0));
		queue_beat(poll_beat(1'b0, 12'd0, 9'd0, 9'd0));
		queue_beat(tick_beat());
		queue_beat(poll_beat(1'b1, 12'd4094, 9'd0, 9'd511));
		wait_drained();

		// A zero move length finishes a started move at once.
		set_config(0, 0, 0);
		queue_beat(poll_beat(1'b0, 12'd0, 9'd0, 9'd0));
		queue_beat(poll_beat(1'b1, 12'd0, 9'd0, 9'd0));
		queue_beat(tick_beat());
		wait_drained();

		for (seg = 0; seg < 8; seg++) begin
			case (seg)
				0: set_config(4095, 511, 1);
				1: set_config(0, 0, 65535);
				2: set_config(rgsc_pkg::PRESSURE_LIMIT_RST, rgsc_pkg::FULL_DISTANCE_RST, 200);
				default: set_config($urandom_range(0, 4095), $urandom_range(0, 511),
					$urandom_range(1, 12));
			endcase
			idle_on = (seg != 3 && seg != 7);
			queue_runs(150);
			wait_drained();
		end

		if (mismatches == 0)
			$display("rain_gate_stepper_controller_core_tb passed");
		else
			$display("rain_gate_stepper_controller_core_tb failed");
		$finish;
	end

endmodule

### sim.f
hdl/rgsc_pkg.sv
hdl/rgsc_step.sv
hdl/rain_gate_stepper_controller_core.sv
bench/rain_gate_stepper_controller_core_tb.sv
